// ----- rtl/fixed_priority_task_scheduler_top_defines.svh -----
// ----------------------------------------------------------------------------
// fixed priority task scheduler assertion macros
// shared concurrent assertion forms for the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef FIXED_PRIORITY_TASK_SCHEDULER_TOP_DEFINES_SVH
`define FIXED_PRIORITY_TASK_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define FPTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define FPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fpts_pkg.sv -----
// ----------------------------------------------------------------------------
// fpts_pkg
// types and constants of the fixed priority task scheduler
// ----------------------------------------------------------------------------
package fpts_pkg;

    localparam int TIME_W     = 32;
    localparam int FIELD_W    = 16;
    localparam int PRIO_W     = 8;
    localparam int IDX_W      = 4;
    localparam int ACTIVE_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [TIME_W-1:0] MAX_TICKS_RESET = 32'd1000000;

    // input word modes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TICKS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_REL,
        ST_EXE,
        ST_OUT
    } t_state;

    // one task table row
    typedef struct packed {
        logic [FIELD_W-1:0] period;
        logic [FIELD_W-1:0] exec;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  next_release;
        logic [TIME_W-1:0]  next_deadline;
        logic [FIELD_W-1:0] remaining;
    } t_entry;

    typedef struct packed {
        logic [TIME_W-1:0] tick_time;
        logic              running_valid;
        logic [IDX_W-1:0]  running_task;
        logic              job_done;
        logic              deadline_missed;
        logic [IDX_W-1:0]  missed_task;
        logic              finished;
    } t_result;

endpackage

// ----- rtl/fpts_if.sv -----
// ----------------------------------------------------------------------------
// fpts_if
// valid/ready channels of the scheduler: command words in, result words out
// ----------------------------------------------------------------------------
interface fpts_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [fpts_pkg::IDX_W-1:0]   task_index;
    logic [fpts_pkg::FIELD_W-1:0] release_time;
    logic [fpts_pkg::FIELD_W-1:0] period;
    logic [fpts_pkg::FIELD_W-1:0] exec_time;
    logic [fpts_pkg::FIELD_W-1:0] rel_deadline;
    logic [fpts_pkg::PRIO_W-1:0]  priority_req;

    modport source (
        output valid, mode, task_index, release_time, period, exec_time,
               rel_deadline, priority_req,
        input  ready
    );
    modport sink (
        input  valid, mode, task_index, release_time, period, exec_time,
               rel_deadline, priority_req,
        output ready
    );
endinterface

interface fpts_out_if;
    logic                        valid;
    logic                        ready;
    logic [fpts_pkg::TIME_W-1:0] tick_time;
    logic                        running_valid;
    logic [fpts_pkg::IDX_W-1:0]  running_task;
    logic                        job_done;
    logic                        deadline_missed;
    logic [fpts_pkg::IDX_W-1:0]  missed_task;
    logic                        finished;

    modport source (
        output valid, tick_time, running_valid, running_task, job_done,
               deadline_missed, missed_task, finished,
        input  ready
    );
    modport sink (
        input  valid, tick_time, running_valid, running_task, job_done,
               deadline_missed, missed_task, finished,
        output ready
    );
endinterface

// ----- rtl/fixed_priority_task_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// fixed_priority_task_scheduler_top
// tick driven preemptive fixed priority scheduler around one task table memory
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            word
//  i_cmd     in   valid/ready          load of one task row, or one tick
//  o_res     out  valid/ready          one result per tick, none per load
//  i_cfg_*   in   write enable only    active_tasks, max_ticks
//
//  a load is written to the table straight from idle; a tick makes one pass over
//  the active entries for deadline checks, one for releases and priority
//  selection, then a read and write back of the winner, all through the
//  single read / single write port of the task table
//  a tick past the limit or after a halt goes straight to the result stage
//  reset is synchronous; ready bits sit in flops, the table needs no clearing
//  results wait in an output register, the next word is taken meanwhile
//
`include "fixed_priority_task_scheduler_top_defines.svh"

module fixed_priority_task_scheduler_top #(
    parameter int N_TASKS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    fpts_in_if.sink                             i_cmd,
    fpts_out_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [fpts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fpts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // table address width and a counter able to hold the active count
    localparam int IW = (N_TASKS > 1) ? $clog2(N_TASKS) : 1;
    localparam int CW = $clog2(N_TASKS + 1);

    // task table memory, one row per task
    fpts_pkg::t_entry r_mem [N_TASKS];
    fpts_pkg::t_entry r_rd_q;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             mem_we;
    logic [IW-1:0]    wr_addr;
    fpts_pkg::t_entry wr_data;

    fpts_pkg::t_state r_state, n_state;

    // scheduler state
    logic [N_TASKS-1:0]             r_ready, n_ready;
    logic [fpts_pkg::TIME_W-1:0]    r_cur, n_cur;
    logic                           r_stopped, n_stopped;
    logic                           r_held_valid, n_held_valid;
    logic [IW-1:0]                  r_held_task, n_held_task;

    // configuration
    logic [fpts_pkg::ACTIVE_W-1:0]  r_active, n_active;
    logic [fpts_pkg::TIME_W-1:0]    r_max, n_max;

    // scan pipeline: address issued, and the row whose data is now in r_rd_q
    logic [CW-1:0]                  r_idx, n_idx;
    logic                           r_pend, n_pend;
    logic [IW-1:0]                  r_pidx, n_pidx;

    // running priority selection during the release pass
    logic                           r_best_valid, n_best_valid;
    logic [IW-1:0]                  r_best, n_best;
    logic [fpts_pkg::PRIO_W-1:0]    r_best_pri, n_best_pri;
    logic                           r_held_ok, n_held_ok;
    logic [fpts_pkg::PRIO_W-1:0]    r_held_pri, n_held_pri;
    logic [IW-1:0]                  r_sel, n_sel;

    // result staging and output register
    fpts_pkg::t_result              r_res, n_res;
    fpts_pkg::t_result              r_out, n_out;
    logic                           r_out_valid, n_out_valid;

    logic [CW-1:0]                  n_act;
    logic                           scan_more;
    logic                           cmd_acc;
    logic                           load_ok;
    logic [IW-1:0]                  load_addr;
    logic                           ready_p;
    logic                           rel;
    logic                           keep_held;

    // active count clipped to the table depth
    always_comb begin
        if (32'(r_active) > 32'(N_TASKS)) begin
            n_act = CW'(N_TASKS);
        end else begin
            n_act = CW'(r_active);
        end
    end

    assign scan_more = (r_idx < n_act);
    assign cmd_acc   = i_cmd.valid && (r_state == fpts_pkg::ST_IDLE);
    assign load_ok   = (32'(i_cmd.task_index) < 32'(N_TASKS));
    assign load_addr = IW'(i_cmd.task_index);
    assign ready_p   = r_ready[r_pidx];
    assign keep_held = r_held_valid && r_held_ok && (r_held_pri <= r_best_pri);

    assign i_cmd.ready = (r_state == fpts_pkg::ST_IDLE);

    // next state and datapath
    always_comb begin
        n_state      = r_state;
        n_ready      = r_ready;
        n_cur        = r_cur;
        n_stopped    = r_stopped;
        n_held_valid = r_held_valid;
        n_held_task  = r_held_task;
        n_active     = r_active;
        n_max        = r_max;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_best_valid = r_best_valid;
        n_best       = r_best;
        n_best_pri   = r_best_pri;
        n_held_ok    = r_held_ok;
        n_held_pri   = r_held_pri;
        n_sel        = r_sel;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        rd_en        = 1'b0;
        rd_addr      = IW'(r_idx);
        mem_we       = 1'b0;
        wr_addr      = r_pidx;
        wr_data      = r_rd_q;
        rel          = 1'b0;

        // configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpts_pkg::CFG_ACTIVE:    n_active = i_cfg_data[fpts_pkg::ACTIVE_W-1:0];
                fpts_pkg::CFG_MAX_TICKS: n_max    = i_cfg_data;
            endcase
        end

        // result register drains
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            fpts_pkg::ST_IDLE: begin
                if (cmd_acc) begin
                    if (i_cmd.mode == fpts_pkg::MODE_LOAD) begin
                        if (load_ok) begin
                            mem_we                = 1'b1;
                            wr_addr               = load_addr;
                            wr_data.period        = i_cmd.period;
                            wr_data.exec          = i_cmd.exec_time;
                            wr_data.prio          = i_cmd.priority_req;
                            wr_data.next_release  = 32'(i_cmd.release_time);
                            wr_data.next_deadline = 32'(i_cmd.release_time)
                                                  + 32'(i_cmd.rel_deadline);
                            wr_data.remaining     = i_cmd.exec_time;
                            n_ready[load_addr]    = 1'b0;
                            if (r_held_valid && (r_held_task == load_addr)) begin
                                n_held_valid = 1'b0;
                            end
                        end
                    end else begin
                        n_res           = '0;
                        n_res.tick_time = r_cur;
                        if (r_stopped || (r_cur >= r_max)) begin
                            n_res.finished = 1'b1;
                            n_state        = fpts_pkg::ST_OUT;
                        end else begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = fpts_pkg::ST_CHK;
                        end
                    end
                end
            end

            // deadline pass, stops at the lowest missing index
            fpts_pkg::ST_CHK: begin
                n_pend = 1'b0;
                if (scan_more) begin
                    rd_en  = 1'b1;
                    n_idx  = CW'(r_idx + CW'(1));
                    n_pend = 1'b1;
                    n_pidx = IW'(r_idx);
                end
                if (r_pend && ready_p && (r_cur > r_rd_q.next_deadline)) begin
                    n_stopped             = 1'b1;
                    n_res.deadline_missed = 1'b1;
                    n_res.missed_task     = fpts_pkg::IDX_W'(r_pidx);
                    n_pend                = 1'b0;
                    n_state               = fpts_pkg::ST_OUT;
                end else if (!scan_more) begin
                    n_idx        = '0;
                    n_best_valid = 1'b0;
                    n_held_ok    = 1'b0;
                    n_state      = fpts_pkg::ST_REL;
                end
            end

            // release pass with running minimum priority search
            fpts_pkg::ST_REL: begin
                n_pend = 1'b0;
                if (scan_more) begin
                    rd_en  = 1'b1;
                    n_idx  = CW'(r_idx + CW'(1));
                    n_pend = 1'b1;
                    n_pidx = IW'(r_idx);
                end
                if (r_pend) begin
                    rel = !ready_p && (r_cur == r_rd_q.next_release);
                    if (rel) begin
                        mem_we               = 1'b1;
                        wr_addr              = r_pidx;
                        wr_data.next_release = r_rd_q.next_release + 32'(r_rd_q.period);
                        n_ready[r_pidx]      = 1'b1;
                    end
                    if (ready_p || rel) begin
                        if (!r_best_valid || (r_rd_q.prio < r_best_pri)) begin
                            n_best_valid = 1'b1;
                            n_best       = r_pidx;
                            n_best_pri   = r_rd_q.prio;
                        end
                        if (r_held_valid && (r_pidx == r_held_task)) begin
                            n_held_ok  = 1'b1;
                            n_held_pri = r_rd_q.prio;
                        end
                    end
                end else if (!scan_more) begin
                    // held task wins ties, otherwise the lowest index at minimum
                    if (keep_held || r_best_valid) begin
                        n_sel   = keep_held ? r_held_task : r_best;
                        rd_en   = 1'b1;
                        rd_addr = keep_held ? r_held_task : r_best;
                        n_state = fpts_pkg::ST_EXE;
                    end else begin
                        n_held_valid = 1'b0;
                        n_cur        = r_cur + 32'd1;
                        n_state      = fpts_pkg::ST_OUT;
                    end
                end
            end

            // run the chosen task one tick and write its row back
            fpts_pkg::ST_EXE: begin
                mem_we              = 1'b1;
                wr_addr             = r_sel;
                n_res.running_valid = 1'b1;
                n_res.running_task  = fpts_pkg::IDX_W'(r_sel);
                if (r_rd_q.remaining <= 16'd1) begin
                    wr_data.remaining     = r_rd_q.exec;
                    wr_data.next_deadline = r_rd_q.next_deadline + 32'(r_rd_q.period);
                    n_ready[r_sel]        = 1'b0;
                    n_held_valid          = 1'b0;
                    n_res.job_done        = 1'b1;
                end else begin
                    wr_data.remaining = r_rd_q.remaining - 16'd1;
                    n_held_valid      = 1'b1;
                    n_held_task       = r_sel;
                end
                n_cur   = r_cur + 32'd1;
                n_state = fpts_pkg::ST_OUT;
            end

            fpts_pkg::ST_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = fpts_pkg::ST_IDLE;
                end
            end

            default: n_state = fpts_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready      <= '0;
            r_cur        <= '0;
            r_stopped    <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_task  <= '0;
            r_active     <= '0;
            r_max        <= fpts_pkg::MAX_TICKS_RESET;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_best_valid <= 1'b0;
            r_held_ok    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_ready      <= n_ready;
            r_cur        <= n_cur;
            r_stopped    <= n_stopped;
            r_held_valid <= n_held_valid;
            r_held_task  <= n_held_task;
            r_active     <= n_active;
            r_max        <= n_max;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_best_valid <= n_best_valid;
            r_held_ok    <= n_held_ok;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_best     <= n_best;
        r_best_pri <= n_best_pri;
        r_held_pri <= n_held_pri;
        r_sel      <= n_sel;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // task table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_q <= r_mem[rd_addr];
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.tick_time       = r_out.tick_time;
    assign o_res.running_valid   = r_out.running_valid;
    assign o_res.running_task    = r_out.running_task;
    assign o_res.job_done        = r_out.job_done;
    assign o_res.deadline_missed = r_out.deadline_missed;
    assign o_res.missed_task     = r_out.missed_task;
    assign o_res.finished        = r_out.finished;

    // a halt is permanent
    `FPTS_ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, r_stopped, r_stopped, "halt was cleared")

    // the held task always has its ready bit set
    `FPTS_ASSERT_NOW(a_held_ready, i_clk, i_rst_n, r_held_valid, r_ready[r_held_task], "held task not ready")

    // a miss result carries no running task and no finished flag
    `FPTS_ASSERT_NOW(a_miss_clean, i_clk, i_rst_n, r_out_valid && r_out.deadline_missed, !r_out.running_valid && !r_out.finished, "miss result mixed")

    // scan reads are pending only during the scan passes
    `FPTS_ASSERT_NOW(a_pend_scan, i_clk, i_rst_n, r_pend, (r_state == fpts_pkg::ST_CHK) || (r_state == fpts_pkg::ST_REL), "scan read outside a pass")

endmodule
